// ===== rtl/tmcw_pkg.sv =====
`default_nettype none

package tmcw_pkg;

    localparam int SCREEN_WIDTH_DEF  = 80;
    localparam int SCREEN_HEIGHT_DEF = 25;
    localparam int TAB_SPACES_DEF    = 4;

    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int CELL_W    = 16;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;

    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

    localparam logic [CHAR_W-1:0] TEXT_COLOR_RESET = 8'h07;
    localparam logic [CELL_W-1:0] CELL_RESET       = {TEXT_COLOR_RESET, CODE_SPACE};

    localparam logic ACTION_PUT  = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    typedef enum logic [2:0] {
        KIND_READ,
        KIND_PRINT,
        KIND_TAB,
        KIND_NEWLINE,
        KIND_RETURN,
        KIND_BACKSPACE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] cidx;
        logic               in_range;
    } t_cmd;

    // Head of the request queue, seen by the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

    // Back end to front end.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] color,
                                                    input logic [CHAR_W-1:0] ch);
        return {color, ch};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tmcw_if.sv =====
`default_nettype none

interface tmcw_cmd_if;
    import tmcw_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;

    modport source(output valid, action, char_code, cell_index, input ready);
    modport sink(input valid, action, char_code, cell_index, output ready);
endinterface

interface tmcw_res_if;
    import tmcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_value;
    logic [COL_OUT_W-1:0] cursor_column;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic                 scrolled;

    modport source(output valid, cell_value, cursor_column, cursor_row, scrolled,
                   input ready);
    modport sink(input valid, cell_value, cursor_column, cursor_row, scrolled,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/tmcw_ram.sv =====
`default_nettype none

module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/tmcw_front.sv =====
`default_nettype none

module tmcw_front #(
    parameter int SCREEN_WIDTH  = tmcw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tmcw_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tmcw_cmd_if.sink               i_cmd,
    input  wire tmcw_pkg::t_back_ctl   i_ctl,
    output tmcw_pkg::t_queue_head  o_head
);
    import tmcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    t_cmd w_cmd;
    logic w_push;
    logic w_pop;

    // Sort each request into the operation the back end will carry out.
    always_comb begin
        w_cmd.ch       = i_cmd.char_code;
        w_cmd.cidx     = i_cmd.cell_index;
        w_cmd.in_range = (32'(i_cmd.cell_index) < 32'(CELL_COUNT));
        if (i_cmd.action == ACTION_READ) begin
            w_cmd.kind = KIND_READ;
        end else begin
            case (i_cmd.char_code)
                CODE_NEWLINE:   w_cmd.kind = KIND_NEWLINE;
                CODE_BACKSPACE: w_cmd.kind = KIND_BACKSPACE;
                CODE_TAB:       w_cmd.kind = KIND_TAB;
                CODE_RETURN:    w_cmd.kind = KIND_RETURN;
                default:        w_cmd.kind = KIND_PRINT;
            endcase
        end
    end

    assign i_cmd.ready = (r_count != 2'd2) && !i_ctl.clearing;
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign w_pop       = i_ctl.pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wr_ptr] <= w_cmd;
                r_wr_ptr      <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

`default_nettype wire

// ===== rtl/tmcw_back.sv =====
`default_nettype none

module tmcw_back #(
    parameter int SCREEN_WIDTH  = tmcw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tmcw_pkg::SCREEN_HEIGHT_DEF,
    parameter int TAB_SPACES    = tmcw_pkg::TAB_SPACES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tmcw_pkg::t_queue_head         i_head,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]   i_text_color,
    output tmcw_pkg::t_back_ctl                o_ctl,
    tmcw_res_if.source                         o_res
);
    import tmcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(SCREEN_WIDTH);
    localparam int ROW_W      = $clog2(SCREEN_HEIGHT);
    localparam int REP_W      = $clog2(TAB_SPACES + 1);
    localparam int SUM_W      = ((INDEX_W > ADDR_W) ? INDEX_W : ADDR_W) + 1;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_LINE = ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] LINE_STEP = ADDR_W'(SCREEN_WIDTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RDATA = 3'd2;
    localparam logic [2:0] ST_PUT   = 3'd3;
    localparam logic [2:0] ST_BLANK = 3'd4;

    logic [2:0]        r_state,     n_state;
    logic [ADDR_W-1:0] r_clr_addr,  n_clr_addr;
    logic [COL_W-1:0]  r_col,       n_col;
    logic [ROW_W-1:0]  r_row,       n_row;
    // Physical start of the cursor row and of the top screen row; scrolling
    // moves the top row pointer instead of copying the screen.
    logic [ADDR_W-1:0] r_line_phys, n_line_phys;
    logic [ADDR_W-1:0] r_top_base,  n_top_base;
    logic [COL_W-1:0]  r_bcnt,      n_bcnt;
    logic [REP_W-1:0]  r_rep,       n_rep;
    logic [CHAR_W-1:0] r_char,      n_char;
    logic              r_scrolled,  n_scrolled;

    logic                 r_out_valid;
    logic [CELL_W-1:0]    r_out_value;
    logic [COL_OUT_W-1:0] r_out_col;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic                 r_out_scrolled;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [CELL_W-1:0] w_rdata;
    logic [SUM_W-1:0]  w_rsum;
    logic [SUM_W-1:0]  w_rfold;
    logic              w_slot_free;
    logic              w_finish;
    logic [CELL_W-1:0] w_fin_value;
    logic              w_pop;
    logic [ADDR_W-1:0] w_next_line;
    logic [ADDR_W-1:0] w_next_top;
    logic [COL_W-1:0]  w_col_dec;
    logic [31:0]       w_col32;
    logic [31:0]       w_row32;

    // Logical cell index to physical address, relative to the top row.
    assign w_rsum  = SUM_W'(i_head.cmd.cidx) + SUM_W'(r_top_base);
    assign w_rfold = (w_rsum >= SUM_W'(CELL_COUNT)) ? (w_rsum - SUM_W'(CELL_COUNT)) : w_rsum;
    assign w_raddr = w_rfold[ADDR_W-1:0];

    assign w_next_line = (r_line_phys == LAST_LINE) ? '0 : (r_line_phys + LINE_STEP);
    assign w_next_top  = (r_top_base == LAST_LINE) ? '0 : (r_top_base + LINE_STEP);
    assign w_col_dec   = r_col - 1'b1;
    assign w_slot_free = !r_out_valid || o_res.ready;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_col       = r_col;
        n_row       = r_row;
        n_line_phys = r_line_phys;
        n_top_base  = r_top_base;
        n_bcnt      = r_bcnt;
        n_rep       = r_rep;
        n_char      = r_char;
        n_scrolled  = r_scrolled;
        w_we        = 1'b0;
        w_waddr     = r_line_phys + ADDR_W'(r_col);
        w_wdata     = make_cell(i_text_color, r_char);
        w_pop       = 1'b0;
        w_finish    = 1'b0;
        w_fin_value = '0;
        case (r_state)
            ST_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = CELL_RESET;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_head.valid && w_slot_free) begin
                    w_pop      = 1'b1;
                    n_scrolled = 1'b0;
                    case (i_head.cmd.kind)
                        KIND_READ: begin
                            if (i_head.cmd.in_range) begin
                                n_state = ST_RDATA;
                            end else begin
                                w_finish = 1'b1;
                            end
                        end
                        KIND_NEWLINE: begin
                            n_col       = '0;
                            n_line_phys = w_next_line;
                            if (r_row == LAST_ROW) begin
                                n_scrolled = 1'b1;
                                n_top_base = w_next_top;
                                n_bcnt     = '0;
                                n_rep      = '0;
                                n_state    = ST_BLANK;
                            end else begin
                                n_row    = r_row + 1'b1;
                                w_finish = 1'b1;
                            end
                        end
                        KIND_RETURN: begin
                            n_col    = '0;
                            w_finish = 1'b1;
                        end
                        KIND_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col   = w_col_dec;
                                w_we    = 1'b1;
                                w_waddr = r_line_phys + ADDR_W'(w_col_dec);
                                w_wdata = make_cell(i_text_color, CODE_SPACE);
                            end
                            w_finish = 1'b1;
                        end
                        KIND_PRINT: begin
                            n_char  = i_head.cmd.ch;
                            n_rep   = REP_W'(1);
                            n_state = ST_PUT;
                        end
                        KIND_TAB: begin
                            n_char  = CODE_SPACE;
                            n_rep   = REP_W'(TAB_SPACES);
                            n_state = ST_PUT;
                        end
                        default: begin
                            w_finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_RDATA: begin
                w_finish    = 1'b1;
                w_fin_value = w_rdata;
                n_state     = ST_IDLE;
            end
            ST_PUT: begin
                w_we  = 1'b1;
                n_rep = r_rep - 1'b1;
                if (r_col == LAST_COL) begin
                    n_col       = '0;
                    n_line_phys = w_next_line;
                    if (r_row != LAST_ROW) begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
                if ((r_col == LAST_COL) && (r_row == LAST_ROW)) begin
                    // Wrapped off the bottom: scroll and blank the new last row.
                    n_scrolled = 1'b1;
                    n_top_base = w_next_top;
                    n_bcnt     = '0;
                    n_state    = ST_BLANK;
                end else if (r_rep == REP_W'(1)) begin
                    w_finish = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_BLANK: begin
                w_we    = 1'b1;
                w_waddr = r_line_phys + ADDR_W'(r_bcnt);
                w_wdata = make_cell(i_text_color, CODE_SPACE);
                n_bcnt  = r_bcnt + 1'b1;
                if (r_bcnt == LAST_COL) begin
                    if (r_rep != '0) begin
                        n_state = ST_PUT;
                    end else begin
                        w_finish = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_col32 = 32'(n_col);
    assign w_row32 = 32'(n_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_line_phys <= '0;
            r_top_base  <= '0;
            r_bcnt      <= '0;
            r_rep       <= '0;
            r_scrolled  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_line_phys <= n_line_phys;
            r_top_base  <= n_top_base;
            r_bcnt      <= n_bcnt;
            r_rep       <= n_rep;
            r_scrolled  <= n_scrolled;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        if (w_finish) begin
            r_out_value    <= w_fin_value;
            r_out_col      <= w_col32[COL_OUT_W-1:0];
            r_out_row      <= w_row32[ROW_OUT_W-1:0];
            r_out_scrolled <= n_scrolled;
        end
    end

    tmcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_ctl.pop      = w_pop;
    assign o_ctl.clearing = (r_state == ST_CLEAR);

    assign o_res.valid         = r_out_valid;
    assign o_res.cell_value    = r_out_value;
    assign o_res.cursor_column = r_out_col;
    assign o_res.cursor_row    = r_out_row;
    assign o_res.scrolled      = r_out_scrolled;

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("result presented during the screen clear");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !w_finish)
        else $error("pending result overwritten");

    a_blank_only_on_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BLANK) |-> r_scrolled)
        else $error("blanking a row without a scroll");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_waddr <= LAST_ADDR))
        else $error("screen write beyond the last cell");

    a_read_follows_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDATA) |-> ($past(r_state) == ST_IDLE))
        else $error("read data taken without a dispatched read");

endmodule

`default_nettype wire

// ===== rtl/text_mode_console_writer.sv =====
// Text screen writer with a cursor, fed by one request channel (i_cmd) and
// answering on one result channel (o_res), both valid/ready. A request with
// action 0 interprets char_code at the cursor; action 1 reads the cell at
// cell_index. Every request yields exactly one result with the cell read
// (zero for a put), the cursor after the request and a scroll flag.
// i_cfg_we/i_cfg_wdata set the attribute byte used for written and blanked
// cells; write it only while no request is outstanding.
// Requests enter a two-entry queue and a sequencer works them off one at a
// time through a screen memory with one write port and one registered read
// port: a dispatch step, then one write per cell (printable 1, tab
// TAB_SPACES) or the registered memory read. A scroll also blanks the new
// bottom row; the screen is not copied, a top row pointer moves instead.
// A printable character is dispatched in ST_IDLE and written in ST_PUT, which
// also registers its result unless the write scrolls.
// After reset (synchronous, active low) the sequencer clears all
// SCREEN_WIDTH*SCREEN_HEIGHT cells to light grey spaces, one per cycle;
// i_cmd.ready stays low during that pass.
// A stalled receiver holds the result register; the queue keeps taking up
// to two further requests meanwhile.
`default_nettype none

module text_mode_console_writer #(
    parameter int SCREEN_WIDTH  = tmcw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tmcw_pkg::SCREEN_HEIGHT_DEF,
    parameter int TAB_SPACES    = tmcw_pkg::TAB_SPACES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    tmcw_cmd_if.sink                          i_cmd,
    tmcw_res_if.source                        o_res,
    input  wire logic                         i_cfg_we,
    input  wire logic [tmcw_pkg::CHAR_W-1:0]  i_cfg_wdata
);
    import tmcw_pkg::*;

    logic [CHAR_W-1:0] r_text_color;
    t_queue_head       w_head;
    t_back_ctl         w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= TEXT_COLOR_RESET;
        end else if (i_cfg_we) begin
            r_text_color <= i_cfg_wdata;
        end
    end

    tmcw_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (i_cmd),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    tmcw_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .TAB_SPACES   (TAB_SPACES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_text_color(r_text_color),
        .o_ctl       (w_ctl),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcw_pkg::*;

    localparam int COLS        = SCREEN_WIDTH_DEF;
    localparam int ROWS        = SCREEN_HEIGHT_DEF;
    localparam int CELLS       = COLS * ROWS;
    localparam int TAB_RUN     = TAB_SPACES_DEF;
    localparam int ITEM_GOAL   = 1900;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        logic [CELL_W-1:0]    cell_data;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic                 scrolled;
    } t_cursor_report;

    // Mirror of the screen and cursor; every accepted request is played into it
    // and the report it should produce waits in order for the real one.
    class screen_scoreboard;
        logic [CELL_W-1:0] cells [CELLS];
        int unsigned       row_pos;
        int unsigned       col_pos;
        logic [CHAR_W-1:0] color;
        t_cursor_report    reports [$];
        int unsigned       accepted;
        int unsigned       errors;

        function new();
            color    = TEXT_COLOR_RESET;
            row_pos  = 0;
            col_pos  = 0;
            accepted = 0;
            errors   = 0;
            foreach (cells[i]) cells[i] = {TEXT_COLOR_RESET, CODE_SPACE};
        endfunction

        function int unsigned pending();
            return reports.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_SHOWN) $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        function bit scroll_if_past_bottom();
            if (row_pos < ROWS) return 1'b0;
            for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = {color, CODE_SPACE};
            row_pos = ROWS - 1;
            return 1'b1;
        endfunction

        function bit put_glyph(logic [CHAR_W-1:0] ch);
            cells[row_pos * COLS + col_pos] = {color, ch};
            col_pos++;
            if (col_pos >= COLS) begin
                col_pos = 0;
                row_pos++;
            end
            return scroll_if_past_bottom();
        endfunction

        function void note_request(logic action, logic [CHAR_W-1:0] ch,
                                   logic [INDEX_W-1:0] idx);
            t_cursor_report r;
            bit             scr;
            scr         = 1'b0;
            r.cell_data = '0;
            if (action == ACTION_READ) begin
                if (idx < CELLS) r.cell_data = cells[idx];
            end else begin
                case (ch)
                    CODE_NEWLINE: begin
                        row_pos++;
                        col_pos = 0;
                        scr = scroll_if_past_bottom();
                    end
                    CODE_BACKSPACE: begin
                        if (col_pos != 0) begin
                            col_pos--;
                            cells[row_pos * COLS + col_pos] = {color, CODE_SPACE};
                        end
                    end
                    CODE_TAB: begin
                        for (int k = 0; k < TAB_RUN; k++) scr |= put_glyph(CODE_SPACE);
                    end
                    CODE_RETURN: begin
                        col_pos = 0;
                    end
                    default: begin
                        scr = put_glyph(ch);
                    end
                endcase
            end
            r.col      = col_pos[COL_OUT_W-1:0];
            r.row      = row_pos[ROW_OUT_W-1:0];
            r.scrolled = scr;
            reports.push_back(r);
            accepted++;
        endfunction

        function void check_result(logic [CELL_W-1:0] cell_data,
                                   logic [COL_OUT_W-1:0] col,
                                   logic [ROW_OUT_W-1:0] row, logic scrolled);
            t_cursor_report e;
            if (reports.size() == 0) begin
                note_error($sformatf(
                    "result with nothing outstanding: cell=%h col=%0d row=%0d scrolled=%b",
                    cell_data, col, row, scrolled));
                return;
            end
            e = reports.pop_front();
            if (e.cell_data !== cell_data || e.col !== col || e.row !== row ||
                e.scrolled !== scrolled) begin
                note_error($sformatf(
                    {"expected cell=%h col=%0d row=%0d scrolled=%b, ",
                     "got cell=%h col=%0d row=%0d scrolled=%b"},
                    e.cell_data, e.col, e.row, e.scrolled, cell_data, col, row, scrolled));
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CHAR_W-1:0] cfg_wdata;
    bit                steady;
    bit                hold_req;
    int unsigned       sent;

    screen_scoreboard sb = new();

    tmcw_cmd_if cmd_ch ();
    tmcw_res_if res_ch ();

    text_mode_console_writer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                sb.check_result(res_ch.cell_value, res_ch.cursor_column, res_ch.cursor_row,
                                res_ch.scrolled);
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                sb.note_request(cmd_ch.action, cmd_ch.char_code, cmd_ch.cell_index);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off when the stimulus asks.
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!steady && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat (1 + pick_gap()) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Valid is left high after a request so back-to-back requests never see it
    // lowered and raised in the same step.
    task automatic send_request(input logic action, input logic [CHAR_W-1:0] ch,
                                input logic [INDEX_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.action     <= action;
        cmd_ch.char_code  <= ch;
        cmd_ch.cell_index <= idx;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sent++;
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_request(ACTION_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input logic [INDEX_W-1:0] idx);
        send_request(ACTION_READ, CHAR_W'($urandom_range(0, 255)), idx);
    endtask

    task automatic wait_all_reported();
        cmd_ch.valid <= 1'b0;
        while (sb.accepted != sent || sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_text_color(input logic [CHAR_W-1:0] value);
        wait_all_reported();
        repeat (8) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.color = value;
    endtask

    initial begin
        int          n;
        int          r;
        int          seg;
        int unsigned next_color_at;
        bit          held_once;
        logic [CHAR_W-1:0] ch;

        cmd_ch.valid      <= 1'b0;
        cmd_ch.action     <= ACTION_PUT;
        cmd_ch.char_code  <= '0;
        cmd_ch.cell_index <= '0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        i_rst_n           <= 1'b0;
        steady    = 1'b0;
        hold_req  = 1'b0;
        sent      = 0;
        held_once = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Freshly cleared screen, including a read past the last cell.
        read_cell(0);
        read_cell(INDEX_W'(CELLS - 1));
        read_cell(11'h7FF);
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        read_cell(0);
        read_cell(1);
        read_cell(2);
        put_char(CODE_BACKSPACE);
        read_cell(2);
        put_char(CODE_RETURN);
        // Backspace at the left edge must leave everything alone.
        put_char(CODE_BACKSPACE);
        put_char(CODE_TAB);
        put_char(CODE_NEWLINE);
        set_text_color(8'h00);
        put_char(8'h5A);
        put_char(CODE_TAB);
        read_cell(INDEX_W'(COLS));
        set_text_color(8'hFF);
        put_char(8'h7E);
        put_char(CODE_BACKSPACE);
        read_cell(INDEX_W'(COLS + 5));
        put_char(CODE_NEWLINE);
        read_cell(INDEX_W'(COLS + 1));

        next_color_at = 450;
        while (sent < ITEM_GOAL) begin
            if (sent >= next_color_at) begin
                r = $urandom_range(0, 3);
                set_text_color(r == 0 ? 8'h00 : r == 1 ? 8'hFF :
                               CHAR_W'($urandom_range(0, 255)));
                next_color_at += 450;
            end
            if (!held_once && sent >= 700) begin
                // Keep offering while results are blocked so the queue backs up.
                held_once = 1'b1;
                steady    = 1'b1;
                hold_req  = 1'b1;
                repeat (24) put_char(CHAR_W'($urandom_range(33, 126)));
                steady = 1'b0;
            end
            steady = ($urandom_range(0, 9) == 0);
            seg = $urandom_range(0, 99);
            if (seg < 40) begin
                // A line of text; some are long enough to wrap at the right edge.
                r = $urandom_range(0, 9);
                n = (r < 5) ? $urandom_range(1, 20) :
                    (r < 8) ? $urandom_range(70, 90) : $urandom_range(1, 160);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0) ch = CHAR_W'($urandom_range(0, 255));
                    else ch = CHAR_W'($urandom_range(33, 126));
                    put_char(ch);
                end
                r = $urandom_range(0, 9);
                if (r < 6) put_char(CODE_NEWLINE);
                else if (r < 8) put_char(CODE_RETURN);
            end else if (seg < 60) begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 9);
                    case (r)
                        0: read_cell(0);
                        1: read_cell(INDEX_W'(CELLS - 1));
                        2: read_cell(INDEX_W'($urandom_range(CELLS, 2047)));
                        3, 4, 5: read_cell(INDEX_W'(sb.row_pos * COLS +
                                                    $urandom_range(0, COLS - 1)));
                        default: read_cell(INDEX_W'($urandom_range(0, CELLS - 1)));
                    endcase
                end
            end else if (seg < 78) begin
                repeat ($urandom_range(1, 8)) begin
                    r = $urandom_range(0, 4);
                    case (r)
                        0: put_char(CODE_NEWLINE);
                        1: put_char(CODE_BACKSPACE);
                        2: put_char(CODE_TAB);
                        3: put_char(CODE_RETURN);
                        default: put_char(CHAR_W'($urandom_range(33, 126)));
                    endcase
                end
            end else if (seg < 90) begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(logic'($urandom_range(0, 1)),
                                 CHAR_W'($urandom_range(0, 255)),
                                 INDEX_W'($urandom_range(0, 2047)));
                end
            end else begin
                repeat ($urandom_range(1, 25)) put_char(CODE_TAB);
                repeat ($urandom_range(0, 3)) put_char(CODE_BACKSPACE);
            end
        end
        steady = 1'b0;

        wait_all_reported();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
